@@ hw/rtl/plt_pkg.sv @@
// shared types and constants for the peer liveness table
package plt_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned CntW       = 5;

  // input item kinds
  typedef enum logic [2:0] {
    KIND_HELLO    = 3'd0,
    KIND_RESPONSE = 3'd1,
    KIND_PONG     = 3'd2,
    KIND_TICK     = 3'd3,
    KIND_PICK     = 3'd4
  } kind_e;

  // result event codes
  typedef enum logic [2:0] {
    EV_PROBE    = 3'd0,
    EV_ADDED    = 3'd1,
    EV_UPDATED  = 3'd2,
    EV_FULL     = 3'd3,
    EV_MATCHED  = 3'd4,
    EV_NO_MATCH = 3'd5,
    EV_SELECTED = 3'd6,
    EV_NONE     = 3'd7
  } event_e;

  // configuration register indexes
  localparam logic CFG_INTERVAL = 1'b0;
  localparam logic CFG_LIMIT    = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ID_RD,
    ST_ID_CHK,
    ST_AP_RD,
    ST_AP_CHK,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_MOD,
    ST_SEL_RD,
    ST_SEL_CHK
  } state_e;

  // one table slot
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] addr;
    logic [15:0] port;
    logic        up;
    logic [2:0]  failures;
    logic [31:0] last_probe;
  } slot_t;

  // memory write request
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    slot_t           data;
  } mem_wr_t;

endpackage

@@ hw/rtl/plt_mem.sv @@
// slot memory, one write and one registered read port
module plt_mem (
  input  logic            clk_i,
  input  plt_pkg::mem_wr_t wr_i,
  input  logic [plt_pkg::IdxW-1:0] rd_addr_i,
  output plt_pkg::slot_t  rd_data_o
);
  import plt_pkg::*;

  slot_t mem_q [MaxEntries];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end
endmodule

@@ hw/rtl/plt_mod.sv @@
// restoring remainder of a 31-bit value by a 5-bit count, one bit per cycle
module plt_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] num_i,
  input  logic [4:0]  den_i,
  output logic        done_o,
  output logic [4:0]  rem_o
);
  import plt_pkg::*;

  logic [30:0] num_q, num_d;
  logic [5:0]  rem_q, rem_d;
  logic [4:0]  bit_q, bit_d;
  logic        run_q, run_d;
  logic [5:0]  trial;

  // one shift-subtract step per cycle
  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    bit_d = bit_q;
    run_d = run_q;
    trial = {rem_q[4:0], num_q[30]};
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
      bit_d = 5'd30;
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[29:0], 1'b0};
      rem_d = (trial >= {1'b0, den_i}) ? trial - {1'b0, den_i} : trial;
      if (bit_q == 5'd0) begin
        run_d = 1'b0;
      end else begin
        bit_d = bit_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    bit_q <= bit_d;
  end

  assign done_o = run_q && (bit_q == 5'd0);
  assign rem_o  = rem_d[4:0];
endmodule

@@ hw/rtl/peer_liveness_table.sv @@
// top level of the peer liveness table
// Usage: raise start with kind_i and the peer fields while busy is low;
// the item is taken at that edge and busy stays high until its last result.
// Results appear one per cycle-group on the result ports, marked by
// result_valid_o for a single cycle; last_o flags the final one.
// Each result is taken at the edge closing its cycle; the receiver cannot stall.
// Scans: every table scan reads the slot memory once per slot, with a read
// state, then a check and write-back state; a hello scans twice (ids, then
// address and port); a pick also runs the remainder unit between its scans.
// A tick with nothing due ends with no result.
// Configuration: cfg_valid_i/cfg_ready_o write probe interval (index 0)
// or attempt limit (index 1); ready is high whenever no item is in work.
// Reset: the table is empty, interval 270 ms, attempt limit 3; slots are
// written on append, so no clearing pass runs.
module peer_liveness_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic signed [31:0] peer_id_i,
  input  logic [31:0] peer_addr_i,
  input  logic [15:0] peer_port_i,
  input  logic [31:0] now_ms_i,
  input  logic [30:0] random_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  event_res_o,
  output logic [3:0]  entry_index_o,
  output logic signed [31:0] entry_id_o,
  output logic [31:0] entry_addr_o,
  output logic [15:0] entry_port_o,
  output logic [2:0]  attempt_o,
  output logic        went_down_o,
  output logic        last_o
);
  import plt_pkg::*;

  state_e st_q, st_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [15:0] interval_q;
  logic [2:0]  limit_q;
  logic [2:0]  kind_q;
  logic [31:0] id_q, addr_q, now_q;
  logic [15:0] port_q;
  logic [30:0] rnd_q;
  logic [4:0]  active_q, active_d;
  logic [4:0]  target_q, target_d;

  // registered result
  logic        rv_q, rv_d;
  logic [2:0]  ev_q, ev_d;
  logic [3:0]  ix_q, ix_d;
  logic [31:0] rid_q, rid_d, raddr_q, raddr_d;
  logic [15:0] rport_q, rport_d;
  logic [2:0]  att_q, att_d;
  logic        dn_q, dn_d, lst_q, lst_d;

  mem_wr_t wr;
  logic [IdxW-1:0] rd_addr;
  slot_t rd;
  logic mod_start, mod_done;
  logic [4:0] mod_rem;
  logic [3:0] att_inc;
  logic [2:0] att_sat;
  logic [31:0] age;

  plt_mem u_mem (
    .clk_i,
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd)
  );

  plt_mod u_mod (
    .clk_i,
    .rst_ni,
    .start_i (mod_start),
    .num_i   (rnd_q),
    .den_i   (active_q),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign busy        = (st_q != ST_IDLE);
  assign cfg_ready_o = !busy;
  assign rd_addr     = ptr_q[IdxW-1:0];
  assign att_inc     = {1'b0, rd.failures} + 4'd1;
  assign att_sat     = att_inc[3] ? 3'd7 : att_inc[2:0];
  assign age         = now_q - rd.last_probe;

  // sequencer
  always_comb begin
    st_d     = st_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    active_d = active_q;
    target_d = target_q;
    wr       = '0;
    mod_start = 1'b0;
    rv_d = 1'b0; ev_d = EV_PROBE; ix_d = '0; rid_d = '0; raddr_d = '0;
    rport_d = '0; att_d = '0; dn_d = 1'b0; lst_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        ptr_d = '0;
        active_d = '0;
        if (start) begin
          case (kind_i)
            KIND_HELLO:    st_d = ST_ID_RD;
            KIND_RESPONSE, KIND_PONG: st_d = ST_AP_RD;
            KIND_TICK:     st_d = ST_TICK_RD;
            KIND_PICK:     st_d = ST_CNT_RD;
            default:       st_d = ST_IDLE;
          endcase
        end
      end
      ST_ID_RD: begin
        if (ptr_q == count_q) begin
          // no id match: append or full
          rv_d = 1'b1;
          raddr_d = addr_q;
          rport_d = port_q;
          rid_d = id_q;
          if (count_q < CntW'(MaxEntries)) begin
            ev_d = EV_ADDED;
            ix_d = count_q[IdxW-1:0];
            wr.we = 1'b1;
            wr.addr = count_q[IdxW-1:0];
            wr.data = '{id: id_q, addr: addr_q, port: port_q, up: 1'b1,
                        failures: 3'd0, last_probe: now_q};
            count_d = count_q + CntW'(1);
          end else begin
            ev_d = EV_FULL;
          end
          ptr_d = '0;
          st_d = ST_AP_RD;
        end else begin
          st_d = ST_ID_CHK;
        end
      end
      ST_ID_CHK: begin
        if (rd.id == id_q) begin
          wr.we = 1'b1;
          wr.addr = ptr_q[IdxW-1:0];
          wr.data = rd;
          wr.data.addr = addr_q;
          wr.data.port = port_q;
          wr.data.up = 1'b1;
          rv_d = 1'b1; ev_d = EV_UPDATED; ix_d = ptr_q[IdxW-1:0];
          rid_d = rd.id; raddr_d = addr_q; rport_d = port_q;
          ptr_d = '0;
          st_d = ST_AP_RD;
        end else begin
          ptr_d = ptr_q + CntW'(1);
          st_d = ST_ID_RD;
        end
      end
      ST_AP_RD: begin
        if (ptr_q == count_q) begin
          rv_d = 1'b1; lst_d = 1'b1; ev_d = EV_NO_MATCH;
          raddr_d = addr_q; rport_d = port_q;
          st_d = ST_IDLE;
        end else begin
          st_d = ST_AP_CHK;
        end
      end
      ST_AP_CHK: begin
        if (rd.addr == addr_q && rd.port == port_q) begin
          wr.we = 1'b1;
          wr.addr = ptr_q[IdxW-1:0];
          wr.data = rd;
          wr.data.up = 1'b1;
          if (kind_q != KIND_PONG) wr.data.failures = 3'd0;
          if (kind_q == KIND_HELLO) wr.data.last_probe = now_q;
          rv_d = 1'b1; lst_d = 1'b1; ev_d = EV_MATCHED; ix_d = ptr_q[IdxW-1:0];
          rid_d = rd.id; raddr_d = rd.addr; rport_d = rd.port;
          st_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + CntW'(1);
          st_d = ST_AP_RD;
        end
      end
      ST_TICK_RD: begin
        st_d = (ptr_q == count_q) ? ST_IDLE : ST_TICK_CHK;
      end
      ST_TICK_CHK: begin
        ptr_d = ptr_q + CntW'(1);
        st_d = ST_TICK_RD;
        if (rd.up && age >= {16'd0, interval_q}) begin
          wr.we = 1'b1;
          wr.addr = ptr_q[IdxW-1:0];
          wr.data = rd;
          wr.data.last_probe = now_q;
          wr.data.failures = att_sat;
          rv_d = 1'b1; ev_d = EV_PROBE; ix_d = ptr_q[IdxW-1:0];
          rid_d = rd.id; raddr_d = rd.addr; rport_d = rd.port; att_d = att_sat;
          if (att_sat >= limit_q) begin
            wr.data.up = 1'b0;
            wr.data.failures = 3'd0;
            dn_d = 1'b1;
          end
        end
      end
      ST_CNT_RD: begin
        if (ptr_q == count_q) begin
          if (active_q == '0) begin
            rv_d = 1'b1; lst_d = 1'b1; ev_d = EV_NONE;
            st_d = ST_IDLE;
          end else begin
            mod_start = 1'b1;
            st_d = ST_MOD;
          end
        end else begin
          st_d = ST_CNT_CHK;
        end
      end
      ST_CNT_CHK: begin
        if (rd.up) active_d = active_q + 5'd1;
        ptr_d = ptr_q + CntW'(1);
        st_d = ST_CNT_RD;
      end
      ST_MOD: begin
        if (mod_done) begin
          target_d = mod_rem;
          ptr_d = '0;
          st_d = ST_SEL_RD;
        end
      end
      ST_SEL_RD: begin
        st_d = ST_SEL_CHK;
      end
      ST_SEL_CHK: begin
        ptr_d = ptr_q + CntW'(1);
        st_d = ST_SEL_RD;
        if (rd.up) begin
          if (target_q == '0) begin
            rv_d = 1'b1; lst_d = 1'b1; ev_d = EV_SELECTED; ix_d = ptr_q[IdxW-1:0];
            rid_d = rd.id; raddr_d = rd.addr; rport_d = rd.port;
            st_d = ST_IDLE;
          end else begin
            target_d = target_q - 5'd1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // last flag for ticks: a probe is last when no due slot follows; resolved by
  // holding each probe one slot back
  logic        hold_q, hold_d;
  logic        tick_end;
  assign tick_end = (st_q == ST_TICK_RD) && (ptr_q == count_q);

  always_comb begin
    hold_d = hold_q;
    if (st_q == ST_IDLE) begin
      hold_d = 1'b0;
    end else if (st_q == ST_TICK_CHK && rv_d) begin
      hold_d = 1'b1;
    end else if (tick_end) begin
      hold_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      count_q    <= '0;
      interval_q <= 16'd270;
      limit_q    <= 3'd3;
      rv_q       <= 1'b0;
      hold_q     <= 1'b0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      hold_q  <= hold_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_INTERVAL: interval_q <= cfg_data_i;
          CFG_LIMIT:    limit_q    <= cfg_data_i[2:0];
          default:      ;
        endcase
      end
      // probes are delayed one step; others go straight out
      if (st_q == ST_TICK_CHK) begin
        rv_q <= hold_q && rv_d;
      end else if (tick_end) begin
        rv_q <= hold_q;
      end else begin
        rv_q <= rv_d;
      end
    end
  end

  // payload registers
  logic [2:0]  pev_q;
  logic [3:0]  pix_q;
  logic [31:0] pid_q, paddr_q;
  logic [15:0] pport_q;
  logic [2:0]  patt_q;
  logic        pdn_q;

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && start) begin
      kind_q <= kind_i;
      id_q   <= peer_id_i;
      addr_q <= peer_addr_i;
      port_q <= peer_port_i;
      now_q  <= now_ms_i;
      rnd_q  <= random_value_i;
    end
    ptr_q    <= ptr_d;
    active_q <= active_d;
    target_q <= target_d;
    if (st_q == ST_TICK_CHK && rv_d) begin
      pev_q <= ev_d; pix_q <= ix_d; pid_q <= rid_d; paddr_q <= raddr_d;
      pport_q <= rport_d; patt_q <= att_d; pdn_q <= dn_d;
    end
    if (st_q == ST_TICK_CHK || tick_end) begin
      ev_q <= pev_q; ix_q <= pix_q; rid_q <= pid_q; raddr_q <= paddr_q;
      rport_q <= pport_q; att_q <= patt_q; dn_q <= pdn_q; lst_q <= tick_end;
    end else begin
      ev_q <= ev_d; ix_q <= ix_d; rid_q <= rid_d; raddr_q <= raddr_d;
      rport_q <= rport_d; att_q <= att_d; dn_q <= dn_d; lst_q <= lst_d;
    end
  end

  assign result_valid_o = rv_q;
  assign event_res_o    = ev_q;
  assign entry_index_o  = ix_q;
  assign entry_id_o     = rid_q;
  assign entry_addr_o   = raddr_q;
  assign entry_port_o   = rport_q;
  assign attempt_o      = att_q;
  assign went_down_o    = dn_q;
  assign last_o         = lst_q;
endmodule

@@ hw/rtl/plt_checker.sv @@
// port-level checks for the peer liveness table
module plt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] kind_i,
  input logic       cfg_ready_o,
  input logic       result_valid_o,
  input logic       last_o,
  input logic [2:0] event_res_o,
  input logic [2:0] attempt_o,
  input logic       went_down_o
);
  import plt_pkg::*;

  // a final result frees the block
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy) else $error("busy after last result");
  // an accepted item of a known kind makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i <= KIND_PICK) |=> busy) else $error("item not taken");
  // config only while idle
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy) else $error("config open while busy");
  // down flag only on probes
  a_down_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && went_down_o) |-> (event_res_o == EV_PROBE && attempt_o != 3'd0))
    else $error("down flag off probe");
endmodule

bind peer_liveness_table plt_checker u_plt_checker (.*);
